@@ rtl/jad_pkg.sv @@
// ----------------------------------------------------------------------------
// jad_pkg
// Widths, reset values, register indexes and codes of the joystick axis to
// PWM duty unit.
// ----------------------------------------------------------------------------
package jad_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CAL_W      = 16;
  localparam int MAP_W      = 10;
  localparam int PWM_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [CAL_W-1:0] RST_CAL_MIN  = 16'sd0;
  localparam logic signed [CAL_W-1:0] RST_CAL_MID  = 16'sd16384;
  localparam logic signed [CAL_W-1:0] RST_CAL_MAX  = 16'sd32767;
  localparam logic [MAP_W-1:0]        RST_NEUTRAL  = 10'd512;
  localparam logic [MAP_W-1:0]        RST_MAP_LOW  = 10'd255;
  localparam logic [MAP_W-1:0]        RST_MAP_HIGH = 10'd768;

  localparam logic [MAP_W-1:0] MAP_BOT     = 10'd255;
  localparam logic [MAP_W-1:0] MAP_MID     = 10'd512;
  localparam logic [PWM_W-1:0] PWM_NEUTRAL = 12'd2048;
  localparam int               NEUTRAL_BAND = 30;

  // calibration divide: quotient bits, one per stage
  localparam int CD_STEPS  = 9;
  // duty span divide: quotient bits, two per stage
  localparam int QD_BITS   = 22;
  localparam int QD_STAGES = QD_BITS / 2;
  localparam int DUTY_FRAC = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_MIN  = 3'd0,
    REG_CAL_MID  = 3'd1,
    REG_CAL_MAX  = 3'd2,
    REG_INVERT   = 3'd3,
    REG_NEUTRAL  = 3'd4,
    REG_MAP_LOW  = 3'd5,
    REG_MAP_HIGH = 3'd6
  } jad_reg_t;

  typedef enum logic [1:0] {
    QS_ZERO = 2'd0,
    QS_FULL = 2'd1,
    QS_DIV  = 2'd2
  } jad_qs_t;

endpackage

@@ rtl/jad_if.sv @@
// ----------------------------------------------------------------------------
// jad_if
// Sample and result channels of the joystick axis to PWM duty unit.
// ----------------------------------------------------------------------------
interface jad_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [jad_pkg::SAMPLE_W-1:0]  raw_sample;
  logic                                 source_ok;
  logic                                 hold_neutral;

  modport source (output valid, raw_sample, source_ok, hold_neutral, input ready);
  modport sink   (input valid, raw_sample, source_ok, hold_neutral, output ready);
endinterface

interface jad_out_if;
  logic                         valid;
  logic                         ready;
  logic [jad_pkg::PWM_W-1:0]    pwm_count;
  logic                         axis_active;
  logic [jad_pkg::MAP_W-1:0]    mapped_value;

  modport source (output valid, pwm_count, axis_active, mapped_value, input ready);
  modport sink   (input valid, pwm_count, axis_active, mapped_value, output ready);
endinterface

@@ rtl/joystick_axis_to_pwm_duty_unit.sv @@
// ----------------------------------------------------------------------------
// joystick_axis_to_pwm_duty_unit
// Converts one joystick axis sample into a mapped axis value, an active flag
// and a 12-bit PWM on-count.
//
// Takes one sample word per clock and returns one result word per clock while
// out_chan.ready stays high. The pipeline depth is set mostly by the
// calibration divider (one quotient bit per stage, nine stages) and the
// duty span divider (two quotient bits per stage, eleven stages). A result
// waiting on the output does not stop intake: a skid register takes the next
// word, and in_chan.ready drops only while that register is full.
// Configuration is taken at once but must only be written while no sample is
// in flight.
// ----------------------------------------------------------------------------
module joystick_axis_to_pwm_duty_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  jad_in_if.sink                            in_chan,
  jad_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [jad_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [jad_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CDS = jad_pkg::CD_STEPS;
  localparam int QDS = jad_pkg::QD_STAGES;
  localparam int QDB = jad_pkg::QD_BITS;
  localparam int MW  = jad_pkg::MAP_W;
  localparam int PW  = jad_pkg::PWM_W;

  localparam logic signed [26:0] Q_ONE     = 27'sd1 <<< jad_pkg::DUTY_FRAC;
  localparam logic signed [26:0] Q_HALF    = Q_ONE >>> 1;
  localparam logic signed [26:0] Q_QUARTER = Q_ONE >>> 2;
  localparam logic [36:0]        RND_HALF  = 37'd1 << (jad_pkg::DUTY_FRAC - 1);
  localparam logic signed [11:0] BAND      = 12'(jad_pkg::NEUTRAL_BAND);

  function automatic logic [11:0] qd_step(input logic [10:0] rem, input logic b,
                                          input logic [10:0] den);
    logic [11:0] t;
    logic [11:0] d;
    logic        ge;
    t  = {rem, b};
    d  = t - {1'b0, den};
    ge = (t >= {1'b0, den});
    return {ge, (ge ? d[10:0] : t[10:0])};
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  logic signed [15:0] cal_min_r, cal_mid_r, cal_max_r;
  logic               invert_r;
  logic [MW-1:0]      neutral_r, map_low_r, map_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_min_r  <= jad_pkg::RST_CAL_MIN;
      cal_mid_r  <= jad_pkg::RST_CAL_MID;
      cal_max_r  <= jad_pkg::RST_CAL_MAX;
      invert_r   <= 1'b0;
      neutral_r  <= jad_pkg::RST_NEUTRAL;
      map_low_r  <= jad_pkg::RST_MAP_LOW;
      map_high_r <= jad_pkg::RST_MAP_HIGH;
    end else if (cfg_we) begin
      case (cfg_idx)
        jad_pkg::REG_CAL_MIN:  cal_min_r  <= signed'(cfg_wdata);
        jad_pkg::REG_CAL_MID:  cal_mid_r  <= signed'(cfg_wdata);
        jad_pkg::REG_CAL_MAX:  cal_max_r  <= signed'(cfg_wdata);
        jad_pkg::REG_INVERT:   invert_r   <= cfg_wdata[0];
        jad_pkg::REG_NEUTRAL:  neutral_r  <= cfg_wdata[MW-1:0];
        jad_pkg::REG_MAP_LOW:  map_low_r  <= cfg_wdata[MW-1:0];
        jad_pkg::REG_MAP_HIGH: map_high_r <= cfg_wdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // derived constants, registered from the configuration registers after a write
  logic signed [16:0] md17, mn_c, mx_c, mn_r, mx_r;
  logic [15:0]        cden_lo_r, cden_hi_r;
  logic signed [11:0] no12, ml12, mh12;
  logic signed [11:0] nmin_r, nmax_r, wden_lo_r, wden_hi_r;
  logic signed [26:0] off_r;

  assign md17 = 17'(cal_mid_r);
  assign mx_c = (cal_max_r <= cal_mid_r) ? md17 + 17'sd1 : 17'(cal_max_r);
  assign mn_c = (cal_min_r >= cal_mid_r) ? md17 - 17'sd1 : 17'(cal_min_r);
  assign no12 = signed'({2'b00, neutral_r});
  assign ml12 = signed'({2'b00, map_low_r});
  assign mh12 = signed'({2'b00, map_high_r});

  always_ff @(posedge clk) begin
    mn_r      <= mn_c;
    mx_r      <= mx_c;
    cden_lo_r <= 16'(md17 - mn_c);
    cden_hi_r <= 16'(mx_c - md17);
    nmin_r    <= no12 - BAND;
    nmax_r    <= no12 + BAND;
    wden_lo_r <= no12 - BAND - ml12;
    wden_hi_r <= mh12 - no12 - BAND;
    off_r     <= 27'(12'sd512 - no12) <<< 13;
  end

  // --------------------------------------------------------------------------
  // flow control
  logic en;
  logic out_vld_r, skid_vld_r;

  assign en            = !skid_vld_r;
  assign in_chan.ready = en;

  // --------------------------------------------------------------------------
  // stage 1: capture, inversion
  logic               s1_vld_r, s1_frc_r;
  logic signed [15:0] s1_smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_frc_r <= !in_chan.source_ok || in_chan.hold_neutral;
      s1_smp_r <= invert_r ? 16'sh7FFF - in_chan.raw_sample : in_chan.raw_sample;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: clamp to bounds, pick segment
  logic signed [16:0] s17, sc_lo, sc_hi;
  logic               seg_lo;
  logic               s2_vld_r, s2_frc_r, s2_low_r;
  logic [15:0]        s2_dif_r, s2_den_r;

  assign s17    = 17'(s1_smp_r);
  assign seg_lo = (s17 <= md17);
  assign sc_lo  = (s17 < mn_r) ? mn_r : s17;
  assign sc_hi  = (s17 > mx_r) ? mx_r : s17;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_frc_r <= s1_frc_r;
      s2_low_r <= seg_lo;
      s2_dif_r <= seg_lo ? 16'(sc_lo - mn_r) : 16'(sc_hi - md17);
      s2_den_r <= seg_lo ? cden_lo_r : cden_hi_r;
    end
  end

  // --------------------------------------------------------------------------
  // calibration divide, restoring, one bit per stage
  logic          cd_vld_r [0:CDS];
  logic          cd_frc_r [0:CDS];
  logic          cd_low_r [0:CDS];
  logic [15:0]   cd_den_r [0:CDS];
  logic [15:0]   cd_rem_r [0:CDS];
  logic [CDS-1:0] cd_lo_r [0:CDS];
  logic [CDS-1:0] cd_q_r  [0:CDS];
  logic [24:0]   cd_num;

  assign cd_num = ({9'd0, s2_dif_r} << 8) + (s2_low_r ? {9'd0, s2_dif_r} : 25'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_vld_r[0] <= 1'b0;
    end else if (en) begin
      cd_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd_frc_r[0] <= s2_frc_r;
      cd_low_r[0] <= s2_low_r;
      cd_den_r[0] <= s2_den_r;
      cd_rem_r[0] <= cd_num[24:CDS];
      cd_lo_r[0]  <= cd_num[CDS-1:0];
      cd_q_r[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= CDS; j++) begin : g_cd
    logic [16:0] t, d;
    logic        ge;

    assign t  = {cd_rem_r[j-1], cd_lo_r[j-1][CDS-1]};
    assign d  = t - {1'b0, cd_den_r[j-1]};
    assign ge = (t >= {1'b0, cd_den_r[j-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_vld_r[j] <= 1'b0;
      end else if (en) begin
        cd_vld_r[j] <= cd_vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd_frc_r[j] <= cd_frc_r[j-1];
        cd_low_r[j] <= cd_low_r[j-1];
        cd_den_r[j] <= cd_den_r[j-1];
        cd_rem_r[j] <= ge ? d[15:0] : t[15:0];
        cd_lo_r[j]  <= cd_lo_r[j-1] << 1;
        cd_q_r[j]   <= {cd_q_r[j-1][CDS-2:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // mapped value and limits
  logic [MW-1:0] v_raw, v_cl;
  logic          vv_vld_r, vv_frc_r;
  logic [MW-1:0] vv_val_r;

  assign v_raw = MW'(cd_q_r[CDS]) + (cd_low_r[CDS] ? jad_pkg::MAP_BOT : jad_pkg::MAP_MID);
  assign v_cl  = (v_raw < map_low_r) ? map_low_r : v_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_vld_r <= 1'b0;
    end else if (en) begin
      vv_vld_r <= cd_vld_r[CDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vv_frc_r <= cd_frc_r[CDS];
      vv_val_r <= (v_cl > map_high_r) ? map_high_r : v_cl;
    end
  end

  // --------------------------------------------------------------------------
  // neutral window, span operands
  logic signed [11:0] v12;
  logic               side_lo, side_hi;
  logic               w_vld_r, w_frc_r, w_act_r, w_hi_r;
  logic [MW-1:0]      w_val_r;
  logic signed [11:0] w_num_r, w_den_r;

  assign v12     = signed'({2'b00, vv_val_r});
  assign side_lo = (v12 < nmin_r);
  assign side_hi = (v12 > nmax_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= 1'b0;
    end else if (en) begin
      w_vld_r <= vv_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_frc_r <= vv_frc_r;
      w_val_r <= vv_val_r;
      w_act_r <= side_lo || side_hi;
      w_hi_r  <= side_hi;
      w_num_r <= side_lo ? v12 - ml12 : v12 - nmax_r;
      w_den_r <= side_lo ? wden_lo_r : wden_hi_r;
    end
  end

  // --------------------------------------------------------------------------
  // duty span divide, rounded, two bits per stage
  logic signed [11:0] x_dn, x_nm;
  jad_pkg::jad_qs_t   x_cls;

  assign x_dn = (w_den_r < 0) ? -w_den_r : w_den_r;
  assign x_nm = (w_den_r < 0) ? -w_num_r : w_num_r;

  always_comb begin
    if (!w_act_r || x_dn == 12'sd0 || x_nm <= 12'sd0) begin
      x_cls = jad_pkg::QS_ZERO;
    end else if (x_nm >= x_dn) begin
      x_cls = jad_pkg::QS_FULL;
    end else begin
      x_cls = jad_pkg::QS_DIV;
    end
  end

  logic             qd_vld_r [0:QDS];
  logic             qd_frc_r [0:QDS];
  logic             qd_act_r [0:QDS];
  logic             qd_hi_r  [0:QDS];
  jad_pkg::jad_qs_t qd_cls_r [0:QDS];
  logic [MW-1:0]    qd_val_r [0:QDS];
  logic [10:0]      qd_den_r [0:QDS];
  logic [10:0]      qd_rem_r [0:QDS];
  logic [QDB-1:0]   qd_lo_r  [0:QDS];
  logic [QDB-1:0]   qd_q_r   [0:QDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_vld_r[0] <= 1'b0;
    end else if (en) begin
      qd_vld_r[0] <= w_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_frc_r[0] <= w_frc_r;
      qd_act_r[0] <= w_act_r;
      qd_hi_r[0]  <= w_hi_r;
      qd_cls_r[0] <= x_cls;
      qd_val_r[0] <= w_val_r;
      qd_den_r[0] <= x_dn[10:0];
      qd_rem_r[0] <= x_nm[10:0];
      qd_lo_r[0]  <= QDB'(x_dn[10:1]);
      qd_q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QDS; k++) begin : g_qd
    logic [11:0] st1, st2;

    assign st1 = qd_step(qd_rem_r[k-1], qd_lo_r[k-1][QDB-1], qd_den_r[k-1]);
    assign st2 = qd_step(st1[10:0], qd_lo_r[k-1][QDB-2], qd_den_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_vld_r[k] <= 1'b0;
      end else if (en) begin
        qd_vld_r[k] <= qd_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qd_frc_r[k] <= qd_frc_r[k-1];
        qd_act_r[k] <= qd_act_r[k-1];
        qd_hi_r[k]  <= qd_hi_r[k-1];
        qd_cls_r[k] <= qd_cls_r[k-1];
        qd_val_r[k] <= qd_val_r[k-1];
        qd_den_r[k] <= qd_den_r[k-1];
        qd_rem_r[k] <= st2[10:0];
        qd_lo_r[k]  <= qd_lo_r[k-1] << 2;
        qd_q_r[k]   <= {qd_q_r[k-1][QDB-3:0], st1[11], st2[11]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // duty, offset, clamp
  logic signed [26:0] f_part, f_base, f_duty;
  logic               f1_vld_r, f1_frc_r, f1_act_r;
  logic [MW-1:0]      f1_val_r;
  logic [24:0]        f1_duty_r;

  always_comb begin
    case (qd_cls_r[QDS])
      jad_pkg::QS_FULL: f_part = Q_QUARTER;
      jad_pkg::QS_DIV:  f_part = signed'({5'd0, qd_q_r[QDS]});
      default:          f_part = 27'sd0;
    endcase
  end

  assign f_base = (qd_act_r[QDS] && !qd_hi_r[QDS]) ? Q_QUARTER : Q_HALF;
  assign f_duty = f_base + f_part + off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= qd_vld_r[QDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_frc_r <= qd_frc_r[QDS];
      f1_act_r <= qd_act_r[QDS];
      f1_val_r <= qd_val_r[QDS];
      if (f_duty < 0) begin
        f1_duty_r <= '0;
      end else if (f_duty > Q_ONE) begin
        f1_duty_r <= Q_ONE[24:0];
      end else begin
        f1_duty_r <= f_duty[24:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // count = round(duty * 4095), neutral override
  logic [36:0]   f_prod;
  logic          f2_vld_r, f2_act_r;
  logic [PW-1:0] f2_cnt_r;
  logic [MW-1:0] f2_val_r;

  assign f_prod = ({12'd0, f1_duty_r} << 12) - {12'd0, f1_duty_r} + RND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_cnt_r <= f1_frc_r ? jad_pkg::PWM_NEUTRAL : f_prod[35:24];
      f2_act_r <= f1_frc_r ? 1'b0 : f1_act_r;
      f2_val_r <= f1_frc_r ? jad_pkg::MAP_MID : f1_val_r;
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid
  logic          load_out;
  logic          out_act_r, skid_act_r;
  logic [PW-1:0] out_cnt_r, skid_cnt_r;
  logic [MW-1:0] out_val_r, skid_val_r;

  assign load_out = !out_vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (en) begin
      if (load_out) begin
        out_vld_r <= f2_vld_r;
      end else if (f2_vld_r) begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_chan.ready) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && load_out) begin
      out_cnt_r <= f2_cnt_r;
      out_act_r <= f2_act_r;
      out_val_r <= f2_val_r;
    end else if (!en && out_chan.ready) begin
      out_cnt_r <= skid_cnt_r;
      out_act_r <= skid_act_r;
      out_val_r <= skid_val_r;
    end
    if (en && !load_out && f2_vld_r) begin
      skid_cnt_r <= f2_cnt_r;
      skid_act_r <= f2_act_r;
      skid_val_r <= f2_val_r;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.pwm_count    = out_cnt_r;
  assign out_chan.axis_active  = out_act_r;
  assign out_chan.mapped_value = out_val_r;

endmodule
